### design/slir_pkg.sv
// Shared types and constants for the list insert and reverse block.
package slir_pkg;

    localparam int POS_W = 6;
    localparam int VAL_W = 32;
    localparam int CNT_W = 6;
    localparam int EXT_W = 64;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_REVERSE = 2'd1,
        CMD_SHOW    = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_FIRST,
        S_SHIFT,
        S_PLACE,
        S_REV_RD_LO,
        S_REV_RD_HI,
        S_REV_WR_HI,
        S_REV_WR_LO,
        S_SHOW_RD,
        S_SHOW_EMIT,
        S_RESP
    } state_t;

    typedef enum logic [2:0] {
        RD_LO,
        RD_LO_P1,
        RD_HI,
        RD_HI_M1,
        RD_HI_M2
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_HI_RDATA,
        WR_HI_HOLD,
        WR_LO_RDATA,
        WR_POS_VAL
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    hold_en;
        logic    lo_inc;
        logic    hi_dec;
        logic    len_inc;
        logic    out_load;
        status_t out_status;
        logic    out_elem;
        logic    out_last;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic bad_pos;
        logic full;
        logic empty;
        logic lt_two;
        logic hi_at_pos;
        logic shift_more;
        logic rev_more;
        logic show_last;
        logic out_free;
    } dp_sts_t;

endpackage

### design/slir_if.sv
// Request and response channel interfaces.
interface slir_req_if import slir_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              cmd;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output cmd, output position, output value, input ready);
    modport sink (input valid, input cmd, input position, input value, output ready);
endinterface

interface slir_rsp_if import slir_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic signed [VAL_W-1:0] element;
    logic [CNT_W-1:0]        count;
    logic                    last;

    modport source (output valid, output status, output element, output count, output last,
                    input ready);
    modport sink (input valid, input status, input element, input count, input last,
                  output ready);
endinterface

### design/slir_ctrl.sv
// Command sequencer for the list insert and reverse block.
module slir_ctrl import slir_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t  state_reg;
    state_t  state_next;
    status_t rsp_reg;
    status_t rsp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rsp_reg   <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            rsp_reg   <= rsp_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rsp_next   = rsp_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.cmd)
                    CMD_INSERT:
                    begin
                        priority if (sts.bad_pos)
                        begin
                            rsp_next   = ST_BAD_POS;
                            state_next = S_RESP;
                        end
                        else if (sts.full)
                        begin
                            rsp_next   = ST_FULL;
                            state_next = S_RESP;
                        end
                        else if (sts.hi_at_pos)
                        begin
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            state_next = S_SHIFT_FIRST;
                        end
                    end
                    CMD_REVERSE:
                    begin
                        rsp_next = ST_OK;
                        if (sts.lt_two)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.hi_dec = 1'b1;
                            state_next = S_REV_RD_LO;
                        end
                    end
                    CMD_SHOW:
                    begin
                        if (sts.empty)
                        begin
                            rsp_next   = ST_EMPTY;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            state_next = S_SHOW_RD;
                        end
                    end
                    CMD_NOP:
                    begin
                        rsp_next   = ST_OK;
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SHIFT_FIRST:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_HI_M1;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                // move one element up, fetch the one below it
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_HI_RDATA;
                cmd.hi_dec = 1'b1;
                if (sts.shift_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_HI_M2;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_POS_VAL;
                cmd.len_inc = 1'b1;
                rsp_next    = ST_OK;
                state_next  = S_RESP;
            end
            S_REV_RD_LO:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_LO;
                state_next = S_REV_RD_HI;
            end
            S_REV_RD_HI:
            begin
                cmd.hold_en = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_HI;
                state_next  = S_REV_WR_HI;
            end
            S_REV_WR_HI:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_HI_HOLD;
                state_next = S_REV_WR_LO;
            end
            S_REV_WR_LO:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_LO_RDATA;
                cmd.lo_inc = 1'b1;
                cmd.hi_dec = 1'b1;
                if (sts.rev_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LO_P1;
                    state_next = S_REV_RD_HI;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_SHOW_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_LO;
                state_next = S_SHOW_EMIT;
            end
            S_SHOW_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_OK;
                    cmd.out_elem   = 1'b1;
                    cmd.out_last   = sts.show_last;
                    if (sts.show_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.lo_inc = 1'b1;
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_LO_P1;
                    end
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = rsp_reg;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### design/slir_dp.sv
// Element store, list indexes and response register.
module slir_dp import slir_pkg::*;
#(
    parameter int CAPACITY      = 32,
    parameter int ELEMENT_WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_cmd_t                 cmd,
    output dp_sts_t                 sts,
    input  logic [1:0]              req_cmd,
    input  logic [POS_W-1:0]        req_position,
    input  logic signed [VAL_W-1:0] req_value,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output logic [1:0]              rsp_status,
    output logic signed [VAL_W-1:0] rsp_element,
    output logic [CNT_W-1:0]        rsp_count,
    output logic                    rsp_last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > POS_W) ? LW : POS_W;

    logic [ELEMENT_WIDTH-1:0] mem [CAPACITY];

    cmd_t                     cmd_reg, cmd_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [ELEMENT_WIDTH-1:0] val_reg, val_next;
    logic [LW-1:0]            len_reg, len_next;
    logic [LW-1:0]            lo_reg, lo_next;
    logic [LW-1:0]            hi_reg, hi_next;
    logic [ELEMENT_WIDTH-1:0] hold_reg, hold_next;
    logic [ELEMENT_WIDTH-1:0] rdata_reg;

    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg, out_status_next;
    logic [VAL_W-1:0]         out_element_reg, out_element_next;
    logic [CNT_W-1:0]         out_count_reg, out_count_next;
    logic                     out_last_reg, out_last_next;

    logic [LW-1:0]            rd_full, wr_full;
    logic [AW-1:0]            rd_addr, wr_addr;
    logic [ELEMENT_WIDTH-1:0] wr_data;
    logic signed [EXT_W-1:0]  wide;
    logic [CW-1:0]            pos_c, len_c, hi_c;

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_LO:    rd_full = lo_reg;
            RD_LO_P1: rd_full = lo_reg + LW'(1);
            RD_HI:    rd_full = hi_reg;
            RD_HI_M1: rd_full = hi_reg - LW'(1);
            RD_HI_M2: rd_full = hi_reg - LW'(2);
            default:  rd_full = lo_reg;
        endcase
        unique case (cmd.wr_sel)
            WR_HI_RDATA:
            begin
                wr_full = hi_reg;
                wr_data = rdata_reg;
            end
            WR_HI_HOLD:
            begin
                wr_full = hi_reg;
                wr_data = hold_reg;
            end
            WR_LO_RDATA:
            begin
                wr_full = lo_reg;
                wr_data = rdata_reg;
            end
            WR_POS_VAL:
            begin
                wr_full = LW'(pos_reg);
                wr_data = val_reg;
            end
        endcase
    end

    assign rd_addr = rd_full[AW-1:0];
    assign wr_addr = wr_full[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign wide = EXT_W'($signed(rdata_reg));

    always_comb
    begin
        cmd_next         = cmd_reg;
        pos_next         = pos_reg;
        val_next         = val_reg;
        len_next         = len_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        hold_next        = hold_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_element_next = out_element_reg;
        out_count_next   = out_count_reg;
        out_last_next    = out_last_reg;
        if (cmd.load)
        begin
            cmd_next = cmd_t'(req_cmd);
            pos_next = req_position;
            val_next = ELEMENT_WIDTH'(req_value);
            lo_next  = '0;
            hi_next  = len_reg;
        end
        if (cmd.lo_inc)
        begin
            lo_next = lo_reg + LW'(1);
        end
        if (cmd.hi_dec)
        begin
            hi_next = hi_reg - LW'(1);
        end
        if (cmd.len_inc)
        begin
            len_next = len_reg + LW'(1);
        end
        if (cmd.hold_en)
        begin
            hold_next = rdata_reg;
        end
        if (cmd.out_load)
        begin
            out_valid_next   = 1'b1;
            out_status_next  = cmd.out_status;
            out_element_next = cmd.out_elem ? wide[VAL_W-1:0] : '0;
            out_count_next   = CNT_W'(len_reg);
            out_last_next    = cmd.out_last;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= CMD_NOP;
            len_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_reg       <= cmd_next;
            len_reg       <= len_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        val_reg         <= val_next;
        hold_reg        <= hold_next;
        out_status_reg  <= out_status_next;
        out_element_reg <= out_element_next;
        out_count_reg   <= out_count_next;
        out_last_reg    <= out_last_next;
    end

    assign pos_c = CW'(pos_reg);
    assign len_c = CW'(len_reg);
    assign hi_c  = CW'(hi_reg);

    always_comb
    begin
        sts.cmd        = cmd_reg;
        sts.bad_pos    = pos_c > len_c;
        sts.full       = len_reg == LW'(CAPACITY);
        sts.empty      = len_reg == '0;
        sts.lt_two     = len_reg < LW'(2);
        sts.hi_at_pos  = hi_c == pos_c;
        sts.shift_more = (hi_c - CW'(1)) != pos_c;
        sts.rev_more   = ({1'b0, lo_reg} + (LW + 1)'(2)) < {1'b0, hi_reg};
        sts.show_last  = lo_reg == (len_reg - LW'(1));
        sts.out_free   = !out_valid_reg || rsp_ready;
    end

    assign rsp_valid   = out_valid_reg;
    assign rsp_status  = out_status_reg;
    assign rsp_element = out_element_reg;
    assign rsp_count   = out_count_reg;
    assign rsp_last    = out_last_reg;

endmodule

### design/sequential_list_insert_reverse.sv
// Top level of the ordered list block: insert, reverse and show over a two-port element store.
// Insert moves the elements from the position up one slot, then writes the value there.
// Bad position, full list, reverse of fewer than two elements, empty show and unused command
// go straight to the response. Reverse swaps from the ends inward; show sends each element, one
// per cycle while the response side takes them. The next request is taken the cycle after
// the response is loaded; reset clears the length and control state, not the element store.
module sequential_list_insert_reverse import slir_pkg::*;
#(
    parameter int CAPACITY      = 32,
    parameter int ELEMENT_WIDTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    slir_req_if.sink   req,
    slir_rsp_if.source rsp
);

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    slir_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (dp_sts),
        .cmd       (dp_cmd)
    );

    slir_dp
    #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .sts          (dp_sts),
        .req_cmd      (req.cmd),
        .req_position (req.position),
        .req_value    (req.value),
        .rsp_valid    (rsp.valid),
        .rsp_ready    (rsp.ready),
        .rsp_status   (rsp.status),
        .rsp_element  (rsp.element),
        .rsp_count    (rsp.count),
        .rsp_last     (rsp.last)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while a previous one is in progress");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> dp_sts.out_free)
        else $error("response register overwritten before it was taken");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !dp_cmd.wr_en)
        else $error("element store written while idle");
`endif

endmodule

### tb/sv/tb_sequential_list_insert_reverse.sv
// Self-checking testbench for the ordered list block: directed table, then random requests.
`timescale 1ns / 1ps

module tb_sequential_list_insert_reverse;
    import slir_pkg::*;

    localparam int LIST_CAP  = 32;
    localparam int RAND_REQS = 340;
    localparam int CALM_REQS = 40;

    typedef struct packed {
        status_t                 status;
        logic signed [VAL_W-1:0] element;
        logic [CNT_W-1:0]        count;
        logic                    last;
    } rsp_item_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        logic             typed;
        status_t          status;
        logic [CNT_W-1:0] count;
    } dir_row_t;

    localparam int DIR_ROWS = 20;

    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{CMD_SHOW,    6'd0,  32'h0000_0000, 1'b1, ST_EMPTY,   6'd0},
        '{CMD_REVERSE, 6'd0,  32'h0000_0000, 1'b1, ST_OK,      6'd0},
        '{CMD_NOP,     6'd63, 32'hFFFF_FFFF, 1'b1, ST_OK,      6'd0},
        '{CMD_INSERT,  6'd1,  32'h1234_5678, 1'b1, ST_BAD_POS, 6'd0},
        '{CMD_INSERT,  6'd63, 32'hFFFF_FFFF, 1'b1, ST_BAD_POS, 6'd0},
        '{CMD_INSERT,  6'd0,  32'h7FFF_FFFF, 1'b1, ST_OK,      6'd1},
        '{CMD_REVERSE, 6'd0,  32'h0000_0000, 1'b1, ST_OK,      6'd1},
        '{CMD_SHOW,    6'd0,  32'h0000_0000, 1'b0, ST_OK,      6'd0},
        '{CMD_INSERT,  6'd1,  32'h8000_0000, 1'b1, ST_OK,      6'd2},
        '{CMD_INSERT,  6'd0,  32'hFFFF_FFFF, 1'b1, ST_OK,      6'd3},
        '{CMD_INSERT,  6'd1,  32'h0000_0000, 1'b1, ST_OK,      6'd4},
        '{CMD_INSERT,  6'd4,  32'h0000_0001, 1'b1, ST_OK,      6'd5},
        '{CMD_INSERT,  6'd6,  32'h0000_0002, 1'b1, ST_BAD_POS, 6'd5},
        '{CMD_SHOW,    6'd0,  32'h0000_0000, 1'b0, ST_OK,      6'd0},
        '{CMD_REVERSE, 6'd0,  32'h0000_0000, 1'b1, ST_OK,      6'd5},
        '{CMD_SHOW,    6'd0,  32'h0000_0000, 1'b0, ST_OK,      6'd0},
        '{CMD_INSERT,  6'd2,  32'hA5A5_A5A5, 1'b0, ST_OK,      6'd0},
        '{CMD_REVERSE, 6'd0,  32'h0000_0000, 1'b0, ST_OK,      6'd0},
        '{CMD_SHOW,    6'd0,  32'h0000_0000, 1'b0, ST_OK,      6'd0},
        '{CMD_NOP,     6'd0,  32'h0000_0000, 1'b0, ST_OK,      6'd0}
    };

    logic clk;
    logic rst_n;

    slir_req_if req_ch ();
    slir_rsp_if rsp_ch ();

    sequential_list_insert_reverse #(
        .CAPACITY      (LIST_CAP),
        .ELEMENT_WIDTH (VAL_W)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic signed [VAL_W-1:0] list_mem [0:LIST_CAP-1];
    int                      list_len;
    rsp_item_t               list_out [$];
    rsp_item_t               pending_rsp [$];
    int                      n_bad;
    bit                      no_idle;
    int                      stall_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function void list_apply(input cmd_t c, input logic [POS_W-1:0] p,
                             input logic signed [VAL_W-1:0] v);
        int                      i;
        logic signed [VAL_W-1:0] t;
        list_out.delete();
        case (c)
            CMD_INSERT:
            begin
                if (int'(p) > list_len)
                    list_out.push_back('{ST_BAD_POS, '0, list_len[CNT_W-1:0], 1'b1});
                else if (list_len >= LIST_CAP)
                    list_out.push_back('{ST_FULL, '0, list_len[CNT_W-1:0], 1'b1});
                else
                begin
                    for (i = list_len; i > int'(p); i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[int'(p)] = v;
                    list_len++;
                    list_out.push_back('{ST_OK, '0, list_len[CNT_W-1:0], 1'b1});
                end
            end
            CMD_REVERSE:
            begin
                for (i = 0; i < list_len / 2; i++)
                begin
                    t = list_mem[i];
                    list_mem[i] = list_mem[list_len-1-i];
                    list_mem[list_len-1-i] = t;
                end
                list_out.push_back('{ST_OK, '0, list_len[CNT_W-1:0], 1'b1});
            end
            CMD_SHOW:
            begin
                if (list_len == 0)
                    list_out.push_back('{ST_EMPTY, '0, 6'd0, 1'b1});
                else
                    for (i = 0; i < list_len; i++)
                        list_out.push_back('{ST_OK, list_mem[i], list_len[CNT_W-1:0],
                                             (i == list_len - 1)});
            end
            default:
                list_out.push_back('{ST_OK, '0, list_len[CNT_W-1:0], 1'b1});
        endcase
    endfunction

    task automatic send_request(input cmd_t c, input logic [POS_W-1:0] p,
                                input logic [VAL_W-1:0] v, input logic typed,
                                input status_t st, input logic [CNT_W-1:0] cnt);
        int gap;
        list_apply(c, p, v);
        if (typed)
            pending_rsp.push_back('{st, '0, cnt, 1'b1});
        else
            foreach (list_out[i])
                pending_rsp.push_back(list_out[i]);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.cmd      <= c;
        req_ch.position <= p;
        req_ch.value    <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    function logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        rsp_item_t got;
        rsp_item_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = '{status_t'(rsp_ch.status), rsp_ch.element, rsp_ch.count, rsp_ch.last};
                if (pending_rsp.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected response: st=%0d el=%0d cnt=%0d last=%0d",
                                 got.status, got.element, got.count, got.last);
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (got.status !== want.status || got.element !== want.element ||
                        got.count !== want.count || got.last !== want.last)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display({"mismatch: exp st=%0d el=%0d cnt=%0d last=%0d, ",
                                      "got st=%0d el=%0d cnt=%0d last=%0d"},
                                     want.status, want.element, want.count, want.last,
                                     got.status, got.element, got.count, got.last);
                    end
                end
            end
            if (no_idle)
                rsp_ch.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        #10ms;
        $display("[sequential_list_insert_reverse] ERROR");
        $finish;
    end

    initial
    begin
        int               k;
        int               r;
        cmd_t             c;
        logic [POS_W-1:0] p;
        logic [VAL_W-1:0] v;
        clk             = 1'b0;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.cmd      = CMD_INSERT;
        req_ch.position = '0;
        req_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        list_len        = 0;
        n_bad           = 0;
        no_idle         = 1'b0;
        stall_left      = 0;
        foreach (list_mem[i])
            list_mem[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_ROWS; k++)
            send_request(dir_rows[k].cmd, dir_rows[k].pos, dir_rows[k].val,
                         dir_rows[k].typed, dir_rows[k].status, dir_rows[k].count);

        for (k = 0; k < RAND_REQS; k++)
        begin
            no_idle = (k >= RAND_REQS - CALM_REQS);
            r = $urandom_range(0, 99);
            p = POS_W'($urandom_range(0, 63));
            v = pick_value();
            if (list_len < LIST_CAP)
            begin
                if (r < 65)
                begin
                    c = CMD_INSERT;
                    if ($urandom_range(0, 9) != 0)
                        p = POS_W'($urandom_range(0, list_len));
                end
                else if (r < 80)
                    c = CMD_REVERSE;
                else if (r < 95)
                    c = CMD_SHOW;
                else
                    c = cmd_t'($urandom_range(0, 3));
            end
            else
            begin
                if (r < 35)
                begin
                    c = CMD_INSERT;
                    case ($urandom_range(0, 3))
                        0:       p = POS_W'(LIST_CAP);
                        1:       p = POS_W'(LIST_CAP + 1);
                        2:       p = POS_W'($urandom_range(0, LIST_CAP));
                        default: p = POS_W'($urandom_range(0, 63));
                    endcase
                end
                else if (r < 60)
                    c = CMD_REVERSE;
                else if (r < 85)
                    c = CMD_SHOW;
                else
                    c = cmd_t'($urandom_range(0, 3));
            end
            send_request(c, p, v, 1'b0, ST_OK, '0);
        end
        req_ch.valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (n_bad == 0 && pending_rsp.size() == 0)
            $display("[sequential_list_insert_reverse] OK");
        else
            $display("[sequential_list_insert_reverse] ERROR");
        $finish;
    end

endmodule
